// ----- rtl/sequence_gap_nack_tracker_assert.svh -----
// assertion macros used by the tracker back part (sgnt_back)
`ifndef SEQUENCE_GAP_NACK_TRACKER_ASSERT_SVH
`define SEQUENCE_GAP_NACK_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SGNT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SGNT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sgnt_pkg.sv -----
`default_nettype none
package sgnt_pkg;

	// result kinds
	localparam logic KIND_REQ    = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// register word index
	localparam logic REG_MAX_CHASE   = 1'b0;
	localparam logic REG_PLAY_ENABLE = 1'b1;

	// header size in bytes
	localparam logic [16:0] HDR_BYTES = 17'd24;

	// command queue geometry
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [2:0] {
		ST_SHORT     = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_FIRST     = 3'd2,
		ST_IN_ORDER  = 3'd3,
		ST_GAP       = 3'd4,
		ST_LATE      = 3'd5
	} sgnt_status_t;

	typedef struct packed {
		logic [11:0] packet_len;
		logic [15:0] outer_seq;
		logic [15:0] inner_seq;
		logic [15:0] payload_len;
	} sgnt_in_t;

	typedef struct packed {
		logic         item_kind;
		logic [15:0]  request_seq;
		logic [2:0]   status;
		logic [14:0]  missing_count;
		logic [7:0]   play_count;
		logic         last;
	} sgnt_out_t;

	// classified packet handed from front to back
	typedef struct packed {
		sgnt_status_t status;
		logic [14:0]  miss;
		logic [5:0]   chase;
		logic [15:0]  base_seq;
		logic [7:0]   play;
	} sgnt_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/sgnt_front.sv -----
`default_nettype none
module sgnt_front import sgnt_pkg::*; #(
	parameter int MAX_CHASE    = 32,
	parameter int PLAY_SAMPLES = 160
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire sgnt_in_t  in_data,
	input  wire logic [5:0] max_chase,
	input  wire logic      play_enable,
	input  wire logic      q_full,
	output logic           q_push,
	output sgnt_cmd_t      q_data
);

	localparam logic [15:0] PLAY_LIM  = 16'(PLAY_SAMPLES);
	localparam logic [6:0]  CHASE_CAP = 7'(MAX_CHASE);

	logic [15:0] last_outer_q;
	logic [15:0] last_inner_q;
	logic        have_last_q;

	logic        is_short;
	logic        is_malformed;
	logic [15:0] delta;
	logic        is_gap;
	logic        is_next;
	logic [5:0]  lim;
	logic [14:0] miss;
	logic [15:0] pmin;
	logic [7:0]  play;
	logic        take_seq;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// length checks
	assign is_short     = in_data.packet_len < 12'(HDR_BYTES);
	assign is_malformed = (HDR_BYTES + {1'b0, in_data.payload_len}) >
		{5'd0, in_data.packet_len};

	// inner sequence delta, modulo 2^16
	assign delta   = in_data.inner_seq - last_inner_q;
	assign is_gap  = (delta >= 16'd2) && (delta <= 16'h7FFF);
	assign is_next = delta == 16'd1;
	assign miss    = 15'(delta - 16'd1);

	// request limit is the smaller of register and build cap
	assign lim = ({1'b0, max_chase} < CHASE_CAP) ? max_chase : 6'(MAX_CHASE);

	// play count
	assign pmin = (in_data.payload_len < PLAY_LIM) ? in_data.payload_len : PLAY_LIM;
	assign play = (play_enable && in_data.payload_len != 16'd0) ?
		((pmin > 16'd255) ? 8'hFF : pmin[7:0]) : 8'd0;

	// classify packet
	always_comb begin
		q_data          = '0;
		q_data.base_seq = last_outer_q + 16'd1;
		take_seq        = 1'b0;
		if (is_short) begin
			q_data.status = ST_SHORT;
		end else if (is_malformed) begin
			q_data.status = ST_MALFORMED;
		end else begin
			q_data.play = play;
			if (!have_last_q) begin
				q_data.status = ST_FIRST;
				take_seq      = 1'b1;
			end else if (is_gap) begin
				q_data.status = ST_GAP;
				q_data.miss   = miss;
				q_data.chase  = (miss < {9'd0, lim}) ? miss[5:0] : lim;
				take_seq      = 1'b1;
			end else if (is_next) begin
				q_data.status = ST_IN_ORDER;
				take_seq      = 1'b1;
			end else begin
				q_data.status = ST_LATE;
			end
		end
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_outer_q <= '0;
			last_inner_q <= '0;
			have_last_q  <= 1'b0;
		end else if (q_push && take_seq) begin
			last_outer_q <= in_data.outer_seq;
			last_inner_q <= in_data.inner_seq;
			have_last_q  <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sgnt_fifo.sv -----
`default_nettype none
module sgnt_fifo import sgnt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire sgnt_cmd_t push_data,
	output logic           full,
	input  wire logic      pop,
	output logic           valid,
	output sgnt_cmd_t      pop_data
);

	sgnt_cmd_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full     = count_q == QCNT_W'(QDEPTH);
	assign valid    = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sgnt_back.sv -----
`default_nettype none
`include "sequence_gap_nack_tracker_assert.svh"
module sgnt_back import sgnt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_valid,
	input  wire sgnt_cmd_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output sgnt_out_t      out_data
);

	typedef enum logic {
		B_IDLE,
		B_RUN
	} bstate_t;

	bstate_t    state_q;
	sgnt_cmd_t  cmd_q;
	logic [5:0] idx_q;
	logic       out_valid_q;
	sgnt_out_t  out_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign q_pop     = (state_q == B_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// load a command, then emit its requests and the closing status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cmd_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (q_valid) begin
						cmd_q   <= q_data;
						idx_q   <= '0;
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (slot_free) begin
						out_valid_q         <= 1'b1;
						out_q.missing_count <= cmd_q.miss;
						if (idx_q < cmd_q.chase) begin
							out_q.item_kind   <= KIND_REQ;
							out_q.request_seq <= cmd_q.base_seq + 16'(idx_q);
							out_q.status      <= ST_GAP;
							out_q.play_count  <= '0;
							out_q.last        <= 1'b0;
							idx_q             <= idx_q + 6'd1;
						end else begin
							out_q.item_kind   <= KIND_STATUS;
							out_q.request_seq <= '0;
							out_q.status      <= cmd_q.status;
							out_q.play_count  <= cmd_q.play;
							out_q.last        <= 1'b1;
							state_q           <= B_IDLE;
						end
					end
				end
				default: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// request items belong to a gap and never close a packet
	`SGNT_ASSERT_NOW(a_req_shape, out_valid_q && out_q.item_kind == KIND_REQ,
		out_q.status == ST_GAP && !out_q.last && out_q.play_count == 8'd0,
		"request item with bad fields")

	// status items always close a packet
	`SGNT_ASSERT_NOW(a_status_last, out_valid_q && out_q.item_kind == KIND_STATUS,
		out_q.last && out_q.request_seq == 16'd0, "status item with bad fields")

	// request counter never passes the chase length
	`SGNT_ASSERT_NOW(a_idx_bound, state_q == B_RUN, idx_q <= cmd_q.chase,
		"request counter overran")

	// a loaded command always starts with a cleared counter
	`SGNT_ASSERT_NEXT(a_load_clear, q_pop, state_q == B_RUN && idx_q == 6'd0,
		"command load did not start the run")

endmodule
`default_nettype wire

// ----- rtl/sequence_gap_nack_tracker.sv -----
// Sequence gap tracker: each accepted packet header is classified at once by the
// front part (short, malformed, first, in order, gap, late) and queued in a
// two-entry command queue; the back part then emits one retransmit request
// transfer per cycle, while the output is ready, for the missed outer sequences,
// followed by a single status transfer with last set. The back part handles a
// packet in steps: it loads the command, emits chase requests, then one status,
// where chase is min(missing, max_chase, MAX_CHASE), at most 32 with the default
// limit of 32. Output stalls only hold the back part; the front keeps taking
// headers until the queue is full.
`default_nettype none
module sequence_gap_nack_tracker import sgnt_pkg::*; #(
	parameter int MAX_CHASE    = 32,
	parameter int PLAY_SAMPLES = 160
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire sgnt_in_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output sgnt_out_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [5:0] max_chase_q;
	logic       play_enable_q;
	logic       cfg_wr;
	logic       q_full;
	logic       q_push;
	sgnt_cmd_t  q_in;
	logic       q_valid;
	logic       q_pop;
	sgnt_cmd_t  q_out;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chase_q   <= 6'd32;
			play_enable_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_CHASE:   max_chase_q   <= pwdata[5:0];
				REG_PLAY_ENABLE: play_enable_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[2])
			REG_MAX_CHASE:   prdata = {26'd0, max_chase_q};
			REG_PLAY_ENABLE: prdata = {31'd0, play_enable_q};
			default:         prdata = '0;
		endcase
	end

	sgnt_front #(
		.MAX_CHASE    (MAX_CHASE),
		.PLAY_SAMPLES (PLAY_SAMPLES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.max_chase   (max_chase_q),
		.play_enable (play_enable_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	sgnt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_out)
	);

	sgnt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_out),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import sgnt_pkg::*;

	localparam int CHASE_CAP   = 32;
	localparam int PLAY_CAP    = 160;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 68;
	localparam int NUM_PHASES  = 6;
	localparam int HOLD_CYCLES = 600;
	localparam int SHOW_MAX    = 10;
	localparam int PEND_DEPTH  = 1024;

	// expected stream of requests and status transfers, with its own copy of the tracker state
	class gap_tracker_model;
		sgnt_out_t   pending_items[PEND_DEPTH];
		int          head;
		int          tail;
		int          pending;
		logic [5:0]  max_chase;
		logic        play_enable;
		logic [15:0] last_outer;
		logic [15:0] last_inner;
		bit          have_last;
		int          mismatches;

		function new();
			head        = 0;
			tail        = 0;
			pending     = 0;
			max_chase   = 6'd32;
			play_enable = 1'b1;
			last_outer  = '0;
			last_inner  = '0;
			have_last   = 1'b0;
			mismatches  = 0;
		endfunction

		function void write_reg(logic idx, logic [31:0] val);
			if (idx == REG_MAX_CHASE) begin
				max_chase = val[5:0];
			end else begin
				play_enable = val[0];
			end
		endfunction

		function void push_item(logic kind, logic [15:0] rseq, sgnt_status_t st,
				int miss, int play, logic lst);
			sgnt_out_t r;
			r.item_kind     = kind;
			r.request_seq   = rseq;
			r.status        = st;
			r.missing_count = 15'(miss);
			r.play_count    = 8'(play);
			r.last          = lst;
			if (pending == PEND_DEPTH) begin
				mismatches++;
				return;
			end
			pending_items[tail] = r;
			tail = (tail + 1) % PEND_DEPTH;
			pending++;
		endfunction

		// classify one accepted header and queue what it should produce
		function void take_packet(sgnt_in_t p);
			int need;
			int miss;
			int lim;
			int chase;
			int play;
			logic [15:0] delta;
			sgnt_status_t st;
			need = int'(HDR_BYTES) + int'(p.payload_len);
			miss = 0;
			play = 0;
			if (int'(p.packet_len) < int'(HDR_BYTES)) begin
				push_item(KIND_STATUS, 16'd0, ST_SHORT, 0, 0, 1'b1);
				return;
			end
			if (need > int'(p.packet_len)) begin
				push_item(KIND_STATUS, 16'd0, ST_MALFORMED, 0, 0, 1'b1);
				return;
			end
			if (!have_last) begin
				last_outer = p.outer_seq;
				last_inner = p.inner_seq;
				have_last  = 1'b1;
				st = ST_FIRST;
			end else begin
				delta = p.inner_seq - last_inner;
				if (delta >= 16'd2 && delta <= 16'h7FFF) begin
					// gap: chase the outer sequences right after the last one seen
					miss  = int'(delta) - 1;
					lim   = (int'(max_chase) < CHASE_CAP) ? int'(max_chase) : CHASE_CAP;
					chase = (miss < lim) ? miss : lim;
					for (int i = 0; i < chase; i++) begin
						push_item(KIND_REQ, 16'(int'(last_outer) + 1 + i), ST_GAP, miss, 0, 1'b0);
					end
					last_outer = p.outer_seq;
					last_inner = p.inner_seq;
					st = ST_GAP;
				end else if (delta == 16'd1) begin
					last_outer = p.outer_seq;
					last_inner = p.inner_seq;
					st = ST_IN_ORDER;
				end else begin
					st = ST_LATE;
				end
			end
			if (play_enable && p.payload_len != 16'd0) begin
				play = (int'(p.payload_len) < PLAY_CAP) ? int'(p.payload_len) : PLAY_CAP;
				if (play > 255) begin
					play = 255;
				end
			end
			push_item(KIND_STATUS, 16'd0, st, miss, play, 1'b1);
		endfunction

		// compare one output transfer against the oldest expectation
		function void check_item(sgnt_out_t got);
			sgnt_out_t exp_item;
			if (pending == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX) begin
					$display("unexpected transfer: got %p", got);
				end
				return;
			end
			exp_item = pending_items[head];
			head = (head + 1) % PEND_DEPTH;
			pending--;
			if (got.item_kind !== exp_item.item_kind || got.request_seq !== exp_item.request_seq ||
					got.status !== exp_item.status ||
					got.missing_count !== exp_item.missing_count ||
					got.play_count !== exp_item.play_count || got.last !== exp_item.last) begin
				mismatches++;
				if (mismatches <= SHOW_MAX) begin
					$display("mismatch: expected %p", exp_item);
					$display("          actual   %p", got);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	sgnt_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	sgnt_out_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	gap_tracker_model tracker;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_id = 0;
	int          hold_len = 0;
	logic [15:0] cur_outer = '0;
	logic [15:0] cur_inner = '0;

	sequence_gap_nack_tracker #(
		.MAX_CHASE   (CHASE_CAP),
		.PLAY_SAMPLES(PLAY_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL sequence_gap_nack_tracker");
			$finish;
		end
	end

	// note accepted headers and check output transfers
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			tracker.take_packet(in_data);
		end
		if (arst_n && out_valid && out_ready) begin
			tracker.check_item(out_data);
		end
	end

	// output side: random stalls plus long hold-offs on request
	initial begin : sink_ctrl
		int seen;
		int left;
		seen = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_id != seen) begin
				seen = hold_id;
				left = hold_len;
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (left > 0) begin
				left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	function automatic sgnt_in_t pk(int plen, int oseq, int iseq, int paylen);
		sgnt_in_t p;
		p.packet_len  = 12'(plen);
		p.outer_seq   = 16'(oseq);
		p.inner_seq   = 16'(iseq);
		p.payload_len = 16'(paylen);
		return p;
	endfunction

	// mostly well-formed streams with random gaps, plus late, short, malformed and noise
	function automatic sgnt_in_t make_packet();
		sgnt_in_t p;
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		p.packet_len = 12'($urandom_range(24, 4095));
		if ($urandom_range(0, 1)) begin
			p.payload_len = 16'($urandom_range(0, 200));
		end else begin
			p.payload_len = 16'($urandom_range(0, int'(p.packet_len) - 24));
		end
		if (int'(p.payload_len) > int'(p.packet_len) - 24) begin
			p.payload_len = 16'(int'(p.packet_len) - 24);
		end
		p.outer_seq = cur_outer + 16'd1;
		p.inner_seq = cur_inner + 16'd1;
		if (pick < 64 && pick >= 50) begin
			k = $urandom_range(2, 40);
			p.inner_seq = 16'(int'(cur_inner) + k);
			p.outer_seq = 16'(int'(cur_outer) + k);
		end else if (pick >= 64 && pick < 67) begin
			k = $urandom_range(41, 32767);
			p.inner_seq = 16'(int'(cur_inner) + k);
			p.outer_seq = 16'($urandom);
		end else if (pick >= 67 && pick < 77) begin
			p.inner_seq = 16'(int'(cur_inner) - $urandom_range(0, 32768));
			p.outer_seq = 16'($urandom);
		end else if (pick >= 77 && pick < 85) begin
			p.packet_len  = 12'($urandom_range(0, 23));
			p.outer_seq   = 16'($urandom);
			p.inner_seq   = 16'($urandom);
			p.payload_len = 16'($urandom);
		end else if (pick >= 85 && pick < 93) begin
			p.payload_len = 16'($urandom_range(int'(p.packet_len) - 23, 65535));
			p.outer_seq   = 16'($urandom);
			p.inner_seq   = 16'($urandom);
		end else if (pick >= 93) begin
			p = sgnt_in_t'(60'({$urandom, $urandom}));
		end
		if (pick < 67) begin
			cur_outer = p.outer_seq;
			cur_inner = p.inner_seq;
		end
		return p;
	endfunction

	// offer one header, with random idle cycles first
	task automatic send_packet(input sgnt_in_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	// register write: setup then access
	task automatic reg_write(input logic idx, input int val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tracker.write_reg(idx, 32'(val));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// one edge first so the last accepted header is already noted
	task automatic wait_drained();
		@(posedge clk);
		while (tracker.pending != 0) @(posedge clk);
	endtask

	int phase_chase[NUM_PHASES]  = '{32, 1, 7, 63, 32, 0};
	int phase_play[NUM_PHASES]   = '{1, 1, 0, 1, 1, 1};
	int phase_idle[NUM_PHASES]   = '{0, 64, 0, 27, 0, 27};
	int phase_stall[NUM_PHASES]  = '{0, 0, 64, 27, 0, 27};

	// main sequence
	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed headers at reset settings
		send_packet(pk(0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_packet(pk(23, 0, 0, 0));
		send_packet(pk(24, 16'h1234, 16'h0001, 1));
		send_packet(pk(4095, 0, 0, 16'hFFFF));
		send_packet(pk(24, 16'hFFF0, 16'hFFFE, 0));
		send_packet(pk(4095, 16'hFFF1, 16'hFFFF, 4071));
		send_packet(pk(184, 16'hFFF2, 16'h0000, 160));
		send_packet(pk(183, 16'h0005, 16'h0003, 159));
		send_packet(pk(100, 16'hFFFE, 16'h002B, 1));
		send_packet(pk(64, 16'h0010, 16'h002B, 40));
		send_packet(pk(64, 16'h0011, 16'h802B, 40));
		send_packet(pk(64, 16'h0012, 16'h002A, 40));
		send_packet(pk(2048, 16'hFFFF, 16'h802A, 2024));
		send_packet(pk(2048, 16'h0001, 16'h802B, 2024));
		send_packet(pk(25, 16'h0000, 16'h802C, 1));
		in_valid <= 1'b0;
		wait_drained();

		// zero chase limit still advances on a gap; playback off
		reg_write(REG_MAX_CHASE, 0);
		reg_write(REG_PLAY_ENABLE, 0);
		send_packet(pk(300, 16'h0100, 16'h8040, 200));
		send_packet(pk(300, 16'h0101, 16'h8041, 200));
		in_valid <= 1'b0;
		wait_drained();
		reg_write(REG_MAX_CHASE, 1);
		reg_write(REG_PLAY_ENABLE, 1);
		send_packet(pk(300, 16'h0200, 16'h8050, 276));
		in_valid <= 1'b0;
		cur_outer = 16'h0200;
		cur_inner = 16'h8050;

		// random phases with varying settings and idling
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			reg_write(REG_MAX_CHASE, (ph == NUM_PHASES - 1) ? $urandom_range(1, 32) :
				phase_chase[ph]);
			reg_write(REG_PLAY_ENABLE, phase_play[ph]);
			send_idle_pct = phase_idle[ph];
			stall_pct <= phase_stall[ph];
			if (ph == 4) begin
				// long output hold-off while headers keep coming
				hold_len <= HOLD_CYCLES;
				hold_id  <= hold_id + 1;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_packet(make_packet());
			end
			in_valid <= 1'b0;
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (tracker.pending != 0) begin
			$display("%0d expected transfers never arrived", tracker.pending);
			tracker.mismatches += tracker.pending;
		end
		if (tracker.mismatches == 0) begin
			$display("PASS sequence_gap_nack_tracker");
		end else begin
			$display("FAIL sequence_gap_nack_tracker");
		end
		$finish;
	end

endmodule
